@@ design/lcdu_pkg.sv @@
package lcdu_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int BCD_DIGITS  = 10;
   localparam int BCD_WIDTH   = 4 * BCD_DIGITS;
   localparam int CONV_STEPS  = VALUE_WIDTH;
   localparam int CNT_WIDTH   = 5;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_VERIFY = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic load;
      logic conv;
      logic sum;
      logic finish;
   } lcdu_cmd_type;

   function automatic logic [63:0] pow_ten(input int e);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < e; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

endpackage

@@ design/lcdu_datapath.sv @@
module lcdu_datapath
   import lcdu_pkg::*;
#(
   parameter int PAYLOAD_DIGITS = 8
) (
   input  logic                   clock,
   input  lcdu_cmd_type           cmd,
   input  logic [1:0]             req_op,
   input  logic [VALUE_WIDTH-1:0] req_value_in,
   input  logic                   req_last_in,
   output logic [VALUE_WIDTH-1:0] rsp_value_out,
   output logic                   rsp_passed,
   output logic                   rsp_last_out
);

   localparam logic [63:0] ADD_LIMIT    = pow_ten(PAYLOAD_DIGITS);
   localparam logic [63:0] VERIFY_LIMIT = pow_ten(PAYLOAD_DIGITS + 1);
   localparam logic [31:0] RECIP_TEN    = 32'hCCCC_CCCD;

   logic [1:0]             op_ff, op_in;
   logic                   item_last_ff, item_last_in;
   logic [VALUE_WIDTH-1:0] item_value_ff, item_value_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [3:0]             acc_ff, acc_in;
   logic                   dbl_ff, dbl_in;
   logic                   skip_ff, skip_in;
   logic [3:0]             check_ff, check_in;
   logic [VALUE_WIDTH-1:0] out_value_ff, out_value_in;
   logic                   out_passed_ff, out_passed_in;
   logic                   out_last_ff, out_last_in;

   logic [BCD_WIDTH-1:0]   adj;
   logic [63:0]            recip_prod;
   logic [3:0]             digit;
   logic [4:0]             doubled;
   logic [4:0]             folded;
   logic [4:0]             acc_sum;
   logic [3:0]             check_digit;
   logic [VALUE_WIDTH-1:0] times_ten;
   logic                   add_ok;
   logic                   verify_ok;

   always_comb begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
         adj[4*k +: 4] = (bcd_ff[4*k +: 4] >= 4'd5) ? bcd_ff[4*k +: 4] + 4'd3
                                                   : bcd_ff[4*k +: 4];
      end
   end

   // The quotient by ten is the product with the scaled reciprocal, shifted right by 35.
   assign recip_prod  = {32'd0, item_value_ff} * {32'd0, RECIP_TEN};
   assign digit       = bcd_ff[3:0];
   assign doubled     = {digit, 1'b0};
   assign folded      = dbl_ff ? ((doubled > 5'd9) ? doubled - 5'd9 : doubled)
                               : {1'b0, digit};
   assign acc_sum     = {1'b0, acc_ff} + folded;
   assign check_digit = (acc_ff == 4'd0) ? 4'd0 : 4'd10 - acc_ff;
   assign times_ten   = {item_value_ff[VALUE_WIDTH-4:0], 3'b000}
                      + {item_value_ff[VALUE_WIDTH-2:0], 1'b0}
                      + {{(VALUE_WIDTH-4){1'b0}}, check_digit};
   assign add_ok      = {32'd0, item_value_ff} < ADD_LIMIT;
   assign verify_ok   = ({32'd0, item_value_ff} < VERIFY_LIMIT) && (check_digit == check_ff);

   always_comb begin
      op_in         = op_ff;
      item_last_in  = item_last_ff;
      item_value_in = item_value_ff;
      shift_in      = shift_ff;
      bcd_in        = bcd_ff;
      quot_in       = quot_ff;
      acc_in        = acc_ff;
      dbl_in        = dbl_ff;
      skip_in       = skip_ff;
      check_in      = check_ff;
      out_value_in  = out_value_ff;
      out_passed_in = out_passed_ff;
      out_last_in   = out_last_ff;
      if (cmd.load) begin
         op_in         = req_op;
         item_last_in  = req_last_in;
         item_value_in = req_value_in;
         shift_in      = req_value_in;
         bcd_in        = '0;
         quot_in       = '0;
         acc_in        = '0;
         dbl_in        = 1'b1;
         skip_in       = (req_op != OP_ADD);
         check_in      = '0;
      end
      if (cmd.conv) begin
         bcd_in   = {adj[BCD_WIDTH-2:0], shift_ff[VALUE_WIDTH-1]};
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
      end
      if (cmd.sum) begin
         bcd_in  = {4'd0, bcd_ff[BCD_WIDTH-1:4]};
         quot_in = {3'b000, recip_prod[63:35]};
         if (skip_ff) begin
            check_in = digit;
            skip_in  = 1'b0;
         end else begin
            acc_in = (acc_sum >= 5'd10) ? 4'(acc_sum - 5'd10) : acc_sum[3:0];
            dbl_in = ~dbl_ff;
         end
      end
      if (cmd.finish) begin
         out_last_in   = item_last_ff;
         out_value_in  = '1;
         out_passed_in = 1'b0;
         case (op_ff)
            OP_ADD: begin
               if (add_ok) begin
                  out_value_in  = times_ten;
                  out_passed_in = 1'b1;
               end
            end
            OP_VERIFY: begin
               out_value_in  = '0;
               out_passed_in = verify_ok;
            end
            OP_REMOVE: begin
               if (verify_ok) begin
                  out_value_in  = quot_ff;
                  out_passed_in = 1'b1;
               end
            end
            default: begin
               out_value_in  = '1;
               out_passed_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      item_last_ff  <= item_last_in;
      item_value_ff <= item_value_in;
      shift_ff      <= shift_in;
      bcd_ff        <= bcd_in;
      quot_ff       <= quot_in;
      acc_ff        <= acc_in;
      dbl_ff        <= dbl_in;
      skip_ff       <= skip_in;
      check_ff      <= check_in;
      out_value_ff  <= out_value_in;
      out_passed_ff <= out_passed_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_value_out = out_value_ff;
   assign rsp_passed    = out_passed_ff;
   assign rsp_last_out  = out_last_ff;

endmodule

@@ design/lcdu_ctrl.sv @@
module lcdu_ctrl
   import lcdu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output lcdu_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SUM,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(CONV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(BCD_DIGITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted item did not make the unit busy.");

   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_DONE))
      else $error("Result strobe without a finished item.");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("Result strobe while an item is in progress.");

   a_conv_to_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && cnt_ff == CNT_WIDTH'(CONV_STEPS - 1)) |=> (state_ff == ST_SUM))
      else $error("Conversion did not hand over to digit summing.");
`endif

endmodule

@@ design/luhn_check_digit_unit_top.sv @@
// After the clock edge that accepts an item, the controller steps through bit-serial binary to
// decimal conversion, digit summing and forming the result; the result strobe is registered
// from the done state. The unit takes no new item until it returns to idle; busy drops
// during the result cycle.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous active-high reset returns the controller to idle with no result pending.
module luhn_check_digit_unit_top
   import lcdu_pkg::*;
#(
   parameter int PAYLOAD_DIGITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_op,
   input  logic [VALUE_WIDTH-1:0] req_value_in,
   input  logic                   req_last_in,
   output logic                   rsp_valid,
   output logic [VALUE_WIDTH-1:0] rsp_value_out,
   output logic                   rsp_passed,
   output logic                   rsp_last_out
);

   lcdu_cmd_type cmd;

   lcdu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lcdu_datapath #(
      .PAYLOAD_DIGITS (PAYLOAD_DIGITS)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .req_op        (req_op),
      .req_value_in  (req_value_in),
      .req_last_in   (req_last_in),
      .rsp_value_out (rsp_value_out),
      .rsp_passed    (rsp_passed),
      .rsp_last_out  (rsp_last_out)
   );

endmodule
